[src/rpe_pkg.sv]
package rpe_pkg;

    localparam int RPE_MAX_PAIRS     = 128;
    localparam int RPE_POSITION_BITS = 16;
    localparam int RPE_VALUE_BITS    = 32;

    localparam int RPE_LOG2_BASE_W = 22;
    localparam int RPE_HALF_W      = 8;
    localparam int RPE_CFG_INDEX_W = 1;
    localparam int RPE_CFG_DATA_W  = 22;

    localparam logic [RPE_CFG_INDEX_W-1:0] RPE_REG_LOG2_BASE = 1'd0;
    localparam logic [RPE_CFG_INDEX_W-1:0] RPE_REG_HALF_SIZE = 1'd1;

    localparam logic signed [RPE_LOG2_BASE_W-1:0] RPE_LOG2_BASE_RESET = 22'sd870824;
    localparam logic [RPE_HALF_W-1:0]             RPE_HALF_RESET      = 8'd64;

    // Fraction bits of the exponent, Q1.30 mantissa and signed Q3.30 CORDIC word widths.
    localparam int RPE_FRAC_W     = 16;
    localparam int RPE_MANT_W     = 31;
    localparam int RPE_CORDIC_W   = 34;
    localparam int RPE_CORDIC_STEPS = 30;

    localparam logic [63:0] RPE_INV_TWO_PI = 64'h28BE60DB9391054A;
    localparam logic signed [RPE_CORDIC_W-1:0] RPE_GAIN = 34'sh026DD3B6A;

    localparam logic [31:0] RPE_ATAN [RPE_CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    function automatic logic [63:0] rpe_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = 64'd0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Root of weight 2^(2^-k) in Q1.30, each one the square root of the last.
    function automatic logic [RPE_MANT_W-1:0] rpe_root(input int k);
        logic [63:0] r;
        r = rpe_isqrt(64'd2 << 60);
        for (int j = 1; j < k; j++)
        begin
            r = rpe_isqrt(r << 30);
        end
        return r[RPE_MANT_W-1:0];
    endfunction

endpackage

[src/rpe_if.sv]
interface rpe_feature_if #(
    parameter int POSITION_BITS = rpe_pkg::RPE_POSITION_BITS,
    parameter int PAIR_BITS     = 7,
    parameter int VALUE_BITS    = rpe_pkg::RPE_VALUE_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic [POSITION_BITS-1:0]     position;
    logic [PAIR_BITS-1:0]         pair_no;
    logic signed [VALUE_BITS-1:0] lead_value;
    logic signed [VALUE_BITS-1:0] trail_value;

    modport source (output valid, position, pair_no, lead_value, trail_value,
                    input ready);
    modport sink (input valid, position, pair_no, lead_value, trail_value,
                  output ready);
endinterface

interface rpe_result_if #(
    parameter int VALUE_BITS = rpe_pkg::RPE_VALUE_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] first_result;
    logic signed [VALUE_BITS-1:0] second_result;

    modport source (output valid, first_result, second_result, input ready);
    modport sink (input valid, first_result, second_result, output ready);
endinterface

interface rpe_cfg_if ();
    logic                                   valid;
    logic                                   ready;
    logic [rpe_pkg::RPE_CFG_INDEX_W-1:0]    index;
    logic [rpe_pkg::RPE_CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/rpe_div_cell.sv]
module rpe_div_cell #(
    parameter int MAG_W = 28,
    parameter int BIT   = 0
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [rpe_pkg::RPE_HALF_W-1:0] divisor,
    input  logic [MAG_W-1:0]               num_in,
    input  logic [MAG_W-1:0]               quo_in,
    input  logic [rpe_pkg::RPE_HALF_W-1:0] rem_in,
    output logic [MAG_W-1:0]               num_out,
    output logic [MAG_W-1:0]               quo_out,
    output logic [rpe_pkg::RPE_HALF_W-1:0] rem_out
);
    import rpe_pkg::*;

    logic [RPE_HALF_W:0]   trial;
    logic                  take;
    logic [RPE_HALF_W-1:0] rem_next;
    logic [MAG_W-1:0]      quo_next;
    logic [MAG_W-1:0]      num_reg;
    logic [MAG_W-1:0]      quo_reg;
    logic [RPE_HALF_W-1:0] rem_reg;

    always_comb
    begin
        trial    = {rem_in, num_in[BIT]};
        take     = trial >= {1'b0, divisor};
        quo_next = quo_in;
        if (take)
        begin
            rem_next      = RPE_HALF_W'(trial - {1'b0, divisor});
            quo_next[BIT] = 1'b1;
        end
        else
        begin
            rem_next = trial[RPE_HALF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_in;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign num_out = num_reg;
    assign quo_out = quo_reg;
    assign rem_out = rem_reg;
endmodule

[src/rpe_exp_cell.sv]
module rpe_exp_cell #(
    parameter int K = 1
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [rpe_pkg::RPE_FRAC_W-1:0]  frac_in,
    input  logic [rpe_pkg::RPE_MANT_W-1:0]  mant_in,
    output logic [rpe_pkg::RPE_FRAC_W-1:0]  frac_out,
    output logic [rpe_pkg::RPE_MANT_W-1:0]  mant_out
);
    import rpe_pkg::*;

    localparam logic [RPE_MANT_W-1:0] ROOT = rpe_root(K);

    logic [2*RPE_MANT_W-1:0] prod;
    logic [RPE_MANT_W-1:0]   mant_next;
    logic [RPE_FRAC_W-1:0]   frac_reg;
    logic [RPE_MANT_W-1:0]   mant_reg;

    always_comb
    begin
        prod = mant_in * ROOT;
        if (frac_in[RPE_FRAC_W-K])
            mant_next = prod[RPE_MANT_W+29:30];
        else
            mant_next = mant_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_reg <= frac_in;
            mant_reg <= mant_next;
        end
    end

    assign frac_out = frac_reg;
    assign mant_out = mant_reg;
endmodule

[src/rpe_cordic_cell.sv]
module rpe_cordic_cell #(
    parameter int K = 0
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [rpe_pkg::RPE_CORDIC_W-1:0] x_in,
    input  logic signed [rpe_pkg::RPE_CORDIC_W-1:0] y_in,
    input  logic signed [rpe_pkg::RPE_CORDIC_W-1:0] z_in,
    output logic signed [rpe_pkg::RPE_CORDIC_W-1:0] x_out,
    output logic signed [rpe_pkg::RPE_CORDIC_W-1:0] y_out,
    output logic signed [rpe_pkg::RPE_CORDIC_W-1:0] z_out
);
    import rpe_pkg::*;

    localparam logic signed [RPE_CORDIC_W-1:0] ANGLE =
        $signed({{(RPE_CORDIC_W-32){1'b0}}, RPE_ATAN[K]});

    logic signed [RPE_CORDIC_W-1:0] dx;
    logic signed [RPE_CORDIC_W-1:0] dy;
    logic signed [RPE_CORDIC_W-1:0] x_next;
    logic signed [RPE_CORDIC_W-1:0] y_next;
    logic signed [RPE_CORDIC_W-1:0] z_next;
    logic signed [RPE_CORDIC_W-1:0] x_reg;
    logic signed [RPE_CORDIC_W-1:0] y_reg;
    logic signed [RPE_CORDIC_W-1:0] z_reg;

    always_comb
    begin
        dx = y_in >>> K;
        dy = x_in >>> K;
        if (!z_in[RPE_CORDIC_W-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

[src/rotary_position_embedding_top.sv]
// Rotary position embedding on one feature pair per transfer, fully pipelined:
// one pair is taken every clock cycle unless a finished result is held by a
// stalled result port. The entry stage feeds 21 + PAIR_BITS one-bit divider
// cells, then one exponent split stage, the sixteen exponent cells, five stages
// for the angle in turns and the CORDIC start, the thirty CORDIC cells and two
// rotation stages. While a finished result waits on a stalled result port, the
// whole pipeline holds and no new pair is taken.
// log2_base (register 0, signed Q5.16) and the half head size (register 1) must
// only be written while no pair is in flight.
module rotary_position_embedding_top #(
    parameter int MAX_PAIRS     = rpe_pkg::RPE_MAX_PAIRS,
    parameter int POSITION_BITS = rpe_pkg::RPE_POSITION_BITS,
    parameter int VALUE_BITS    = rpe_pkg::RPE_VALUE_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    rpe_feature_if.sink   feature,
    rpe_result_if.source  rotated,
    rpe_cfg_if.sink       cfg
);
    import rpe_pkg::*;

    localparam int PAIR_BITS = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int MAG_W     = RPE_LOG2_BASE_W - 1 + PAIR_BITS;
    localparam int EXP_W     = MAG_W + 1;
    localparam int SHIFT_W   = EXP_W - RPE_FRAC_W;
    localparam int PROD_W    = POSITION_BITS + RPE_MANT_W;
    localparam int HIGH_W    = PROD_W - 32;
    localparam int TERM_W    = VALUE_BITS + RPE_CORDIC_W;

    localparam int J_EXP   = MAG_W + 1;
    localparam int J_MUL1  = J_EXP + RPE_FRAC_W + 1;
    localparam int J_MUL2  = J_MUL1 + 1;
    localparam int J_SUM   = J_MUL2 + 1;
    localparam int J_PHASE = J_SUM + 1;
    localparam int J_QUAD  = J_PHASE + 1;
    localparam int J_ROT   = J_QUAD + RPE_CORDIC_STEPS + 1;
    localparam int J_OUT   = J_ROT + 1;

    typedef struct packed {
        logic [POSITION_BITS-1:0]     pos;
        logic signed [VALUE_BITS-1:0] a;
        logic signed [VALUE_BITS-1:0] b;
        logic                         neg;
        logic signed [SHIFT_W-1:0]    n;
        logic [1:0]                   qd;
    } side_t;

    logic                              en;
    logic [J_OUT:0]                    valid_reg;
    side_t                             side_reg [J_ROT];
    side_t                             side_next [J_ROT];

    logic signed [RPE_LOG2_BASE_W-1:0] log2_base_reg;
    logic [RPE_HALF_W-1:0]             half_reg;
    logic [RPE_HALF_W-1:0]             divisor;

    // Divider chain.
    logic [MAG_W-1:0]      num_w [MAG_W+1];
    logic [MAG_W-1:0]      quo_w [MAG_W+1];
    logic [RPE_HALF_W-1:0] rem_w [MAG_W+1];
    logic [RPE_LOG2_BASE_W-1:0] base_mag;
    logic [RPE_LOG2_BASE_W+PAIR_BITS-1:0] num_prod;

    // Exponent split and mantissa chain.
    logic signed [EXP_W-1:0] exp_q;
    logic signed [EXP_W-1:0] exp_val;
    logic [RPE_FRAC_W-1:0]   frac_w [RPE_FRAC_W+1];
    logic [RPE_MANT_W-1:0]   mant_w [RPE_FRAC_W+1];
    logic signed [SHIFT_W-1:0] n_val;

    // Angle in turns.
    logic [PROD_W-1:0]  pm_reg;
    logic [63:0]        pp00_reg;
    logic [63:0]        pp01_reg;
    logic [63:0]        pp10_reg;
    logic [63:0]        pp11_reg;
    logic [127:0]       turns_reg;
    logic [31:0]        phi_reg;
    logic signed [SHIFT_W+1:0] tshift;
    logic [159:0]       wide;
    logic [31:0]        phi_next;

    // CORDIC chain.
    logic [1:0]         qd_val;
    logic [31:0]        resid;
    logic signed [RPE_CORDIC_W-1:0] x_w [RPE_CORDIC_STEPS+1];
    logic signed [RPE_CORDIC_W-1:0] y_w [RPE_CORDIC_STEPS+1];
    logic signed [RPE_CORDIC_W-1:0] z_w [RPE_CORDIC_STEPS+1];
    logic signed [RPE_CORDIC_W-1:0] x0_reg;
    logic signed [RPE_CORDIC_W-1:0] y0_reg;
    logic signed [RPE_CORDIC_W-1:0] z0_reg;
    logic signed [RPE_CORDIC_W-1:0] cos_v;
    logic signed [RPE_CORDIC_W-1:0] sin_v;

    // Rotation.
    logic signed [TERM_W-1:0] ac_reg;
    logic signed [TERM_W-1:0] bs_reg;
    logic signed [TERM_W-1:0] bc_reg;
    logic signed [TERM_W-1:0] as_reg;
    logic signed [VALUE_BITS-1:0] first_reg;
    logic signed [VALUE_BITS-1:0] second_reg;

    function automatic logic signed [VALUE_BITS-1:0] round_sat(
        input logic signed [TERM_W-1:0] p,
        input logic signed [TERM_W-1:0] q
    );
        logic signed [TERM_W:0]   sum;
        logic signed [TERM_W-30:0] sh;
        logic signed [TERM_W-30:0] maxv;
        logic signed [TERM_W-30:0] minv;
        sum  = $signed({p[TERM_W-1], p}) + $signed({q[TERM_W-1], q})
               + $signed((TERM_W+1)'(1) << 29);
        sh   = sum[TERM_W:30];
        maxv = (TERM_W-29)'({1'b0, {(VALUE_BITS-1){1'b1}}});
        minv = -maxv - (TERM_W-29)'(1);
        if (sh > maxv)
            return {1'b0, {(VALUE_BITS-1){1'b1}}};
        else if (sh < minv)
            return {1'b1, {(VALUE_BITS-1){1'b0}}};
        else
            return sh[VALUE_BITS-1:0];
    endfunction

    assign en            = !(valid_reg[J_OUT] && !rotated.ready);
    assign feature.ready = en;
    assign cfg.ready     = 1'b1;
    assign divisor       = (half_reg == '0) ? RPE_HALF_W'(1) : half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_base_reg <= RPE_LOG2_BASE_RESET;
            half_reg      <= RPE_HALF_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                RPE_REG_LOG2_BASE: log2_base_reg <= $signed(cfg.data);
                RPE_REG_HALF_SIZE: half_reg      <= cfg.data[RPE_HALF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[J_OUT-1:0], feature.valid};
    end

    // Entry stage: magnitude and sign of -log2_base times the pair number.
    assign base_mag = log2_base_reg[RPE_LOG2_BASE_W-1] ? RPE_LOG2_BASE_W'(-log2_base_reg)
                                                       : RPE_LOG2_BASE_W'(log2_base_reg);
    assign num_prod = base_mag * feature.pair_no;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_w[0] <= num_prod[MAG_W-1:0];
        end
    end
    assign quo_w[0] = '0;
    assign rem_w[0] = '0;

    always_comb
    begin
        side_next[0].pos = feature.position;
        side_next[0].a   = feature.lead_value;
        side_next[0].b   = feature.trail_value;
        side_next[0].neg = !log2_base_reg[RPE_LOG2_BASE_W-1] && (log2_base_reg != '0)
                           && (feature.pair_no != '0);
        side_next[0].n   = '0;
        side_next[0].qd  = '0;
        for (int j = 1; j < J_ROT; j++)
        begin
            side_next[j] = side_reg[j-1];
        end
        side_next[J_EXP].n   = n_val;
        side_next[J_QUAD].qd = qd_val;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < J_ROT; j++)
            begin
                side_reg[j] <= side_next[j];
            end
        end
    end

    // Restoring division, one quotient bit per cell, most significant first.
    for (genvar i = 0; i < MAG_W; i++)
    begin : g_div
        rpe_div_cell #(.MAG_W(MAG_W), .BIT(MAG_W - 1 - i)) u_cell (
            .clk     (clk),
            .en      (en),
            .divisor (divisor),
            .num_in  (num_w[i]),
            .quo_in  (quo_w[i]),
            .rem_in  (rem_w[i]),
            .num_out (num_w[i+1]),
            .quo_out (quo_w[i+1]),
            .rem_out (rem_w[i+1])
        );
    end

    // Floor of the signed quotient, then split into integer and fraction.
    always_comb
    begin
        exp_q = $signed({1'b0, quo_w[MAG_W]});
        if (side_reg[MAG_W].neg)
            exp_val = -(exp_q + EXP_W'(rem_w[MAG_W] != '0));
        else
            exp_val = exp_q;
        n_val = exp_val[EXP_W-1:RPE_FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_w[0] <= exp_val[RPE_FRAC_W-1:0];
            mant_w[0] <= RPE_MANT_W'(1) << 30;
        end
    end

    for (genvar k = 0; k < RPE_FRAC_W; k++)
    begin : g_exp
        rpe_exp_cell #(.K(k + 1)) u_cell (
            .clk      (clk),
            .en       (en),
            .frac_in  (frac_w[k]),
            .mant_in  (mant_w[k]),
            .frac_out (frac_w[k+1]),
            .mant_out (mant_w[k+1])
        );
    end

    // position * 2^e times 1/(2 pi) in Q0.64, split into 32-bit partial products.
    always_comb
    begin
        tshift = (SHIFT_W+2)'(94) - $signed({{2{side_reg[J_SUM].n[SHIFT_W-1]}},
                                             side_reg[J_SUM].n});
        wide   = {turns_reg, 32'd0} >> tshift[7:0];
        if (tshift < 0 || tshift >= (SHIFT_W+2)'(160))
            phi_next = '0;
        else
            phi_next = wide[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_reg    <= side_reg[J_MUL1-1].pos * mant_w[RPE_FRAC_W];
            pp00_reg  <= {32'd0, pm_reg[31:0]} * {32'd0, RPE_INV_TWO_PI[31:0]};
            pp01_reg  <= {32'd0, pm_reg[31:0]} * {32'd0, RPE_INV_TWO_PI[63:32]};
            pp10_reg  <= {{(64-HIGH_W){1'b0}}, pm_reg[PROD_W-1:32]}
                         * {32'd0, RPE_INV_TWO_PI[31:0]};
            pp11_reg  <= {{(64-HIGH_W){1'b0}}, pm_reg[PROD_W-1:32]}
                         * {32'd0, RPE_INV_TWO_PI[63:32]};
            turns_reg <= {64'd0, pp00_reg} + {32'd0, pp01_reg, 32'd0}
                         + {32'd0, pp10_reg, 32'd0} + {pp11_reg, 64'd0};
            phi_reg   <= phi_next;
        end
    end

    // Nearest quarter turn, residual within an eighth of a turn.
    always_comb
    begin
        qd_val = 2'((phi_reg + 32'h20000000) >> 30);
        resid  = phi_reg - ({30'd0, qd_val} << 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= RPE_GAIN;
            y0_reg <= '0;
            z0_reg <= $signed({{(RPE_CORDIC_W-32){resid[31]}}, resid});
        end
    end

    assign x_w[0] = x0_reg;
    assign y_w[0] = y0_reg;
    assign z_w[0] = z0_reg;

    for (genvar k = 0; k < RPE_CORDIC_STEPS; k++)
    begin : g_cordic
        rpe_cordic_cell #(.K(k)) u_cell (
            .clk   (clk),
            .en    (en),
            .x_in  (x_w[k]),
            .y_in  (y_w[k]),
            .z_in  (z_w[k]),
            .x_out (x_w[k+1]),
            .y_out (y_w[k+1]),
            .z_out (z_w[k+1])
        );
    end

    always_comb
    begin
        case (side_reg[J_ROT-1].qd)
            2'd0:
            begin
                cos_v = x_w[RPE_CORDIC_STEPS];
                sin_v = y_w[RPE_CORDIC_STEPS];
            end
            2'd1:
            begin
                cos_v = -y_w[RPE_CORDIC_STEPS];
                sin_v = x_w[RPE_CORDIC_STEPS];
            end
            2'd2:
            begin
                cos_v = -x_w[RPE_CORDIC_STEPS];
                sin_v = -y_w[RPE_CORDIC_STEPS];
            end
            default:
            begin
                cos_v = y_w[RPE_CORDIC_STEPS];
                sin_v = -x_w[RPE_CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg     <= side_reg[J_ROT-1].a * cos_v;
            bs_reg     <= side_reg[J_ROT-1].b * (-sin_v);
            bc_reg     <= side_reg[J_ROT-1].b * cos_v;
            as_reg     <= side_reg[J_ROT-1].a * sin_v;
            first_reg  <= round_sat(ac_reg, bs_reg);
            second_reg <= round_sat(bc_reg, as_reg);
        end
    end

    assign rotated.valid         = valid_reg[J_OUT];
    assign rotated.first_result  = first_reg;
    assign rotated.second_result = second_reg;
endmodule

[dv/rpe_checker.sv]
module rpe_checker (
    input  logic  clk,
    input  logic  rst_n,
    rpe_feature_if feature,
    rpe_result_if  rotated,
    rpe_cfg_if     cfg,
    output int    errors,
    output int    pending
);
    import rpe_pkg::*;

    typedef struct {
        logic signed [31:0] first;
        logic signed [31:0] second;
    } rotated_pair_t;

    rotated_pair_t rotations_due[$];
    logic signed [RPE_LOG2_BASE_W-1:0] log2_base;
    logic [RPE_HALF_W-1:0]             half_size;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] round_sat(input longint sum);
        longint t;
        t = (sum + (64'sd1 <<< 29)) >>> 30;
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t[31:0];
    endfunction

    function automatic rotated_pair_t predict_rotation(input logic [15:0] pos,
                                                       input logic [6:0] pair,
                                                       input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        rotated_pair_t res;
        longint h, num, e, n, x, y, z, dx, dy, c, s, av, bv;
        logic [15:0]  f;
        logic [63:0]  m, r;
        logic [127:0] v;
        logic [31:0]  phi, d;
        logic [1:0]   qd;
        int sh;
        h   = (half_size == 0) ? 1 : longint'(half_size);
        num = -(longint'(log2_base) * longint'(pair));
        e   = num / h;
        if (num % h != 0 && num < 0)
            e = e - 1;
        f = e[15:0];
        n = e >>> 16;
        // Build 2^f from the chain of square roots of two.
        m = 64'd1 << 30;
        r = floor_sqrt(64'd2 << 60);
        for (int k = 1; k <= 16; k++)
        begin
            if (f[16-k])
                m = (m * r) >> 30;
            r = floor_sqrt(r << 30);
        end
        v = {64'd0, 64'(pos) * m} * {64'd0, RPE_INV_TWO_PI};
        if (n > 200 || n < -200)
            phi = 0;
        else
        begin
            sh = 62 - int'(n);
            if (sh >= 128 || sh <= -32)
                phi = 0;
            else if (sh >= 0)
                phi = 32'(v >> sh);
            else
                phi = 32'(v << (-sh));
        end
        qd = 2'((phi + 32'h20000000) >> 30);
        d  = phi - (32'(qd) << 30);
        z  = longint'($signed(d));
        x  = longint'(RPE_GAIN);
        y  = 0;
        for (int k = 0; k < RPE_CORDIC_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(RPE_ATAN[k]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(RPE_ATAN[k]);
            end
        end
        case (qd)
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        av = longint'(a);
        bv = longint'(b);
        res.first  = round_sat(av * c - bv * s);
        res.second = round_sat(bv * c + av * s);
        return res;
    endfunction

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rotated_pair_t want;
        if (!rst_n)
        begin
            log2_base = RPE_LOG2_BASE_RESET;
            half_size = RPE_HALF_RESET;
            rotations_due.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == RPE_REG_LOG2_BASE)
                    log2_base = cfg.data[RPE_LOG2_BASE_W-1:0];
                else if (cfg.index == RPE_REG_HALF_SIZE)
                    half_size = cfg.data[RPE_HALF_W-1:0];
            end
            if (feature.valid && feature.ready)
                rotations_due.insert(rotations_due.size(), predict_rotation(
                    feature.position, feature.pair_no, feature.lead_value,
                    feature.trail_value));
            if (rotated.valid && rotated.ready)
            begin
                if (rotations_due.size() == 0)
                    report("unexpected result transfer", rotated.first_result, 0);
                else
                begin
                    want = rotations_due.pop_front();
                    if (rotated.first_result !== want.first)
                        report("first_result", rotated.first_result, want.first);
                    if (rotated.second_result !== want.second)
                        report("second_result", rotated.second_result, want.second);
                end
            end
        end
        pending = rotations_due.size();
    end

    initial
    begin
        errors  = 0;
        pending = 0;
    end
endmodule

[dv/tb.sv]
module tb;
    import rpe_pkg::*;

    logic clk;
    logic rst_n;
    logic calm;
    int   errors;
    int   pending;

    rpe_feature_if feat ();
    rpe_result_if  rot ();
    rpe_cfg_if     cfg_ch ();

    rotary_position_embedding_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .feature (feat),
        .rotated (rot),
        .cfg     (cfg_ch)
    );

    rpe_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .feature (feat),
        .rotated (rot),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #5 clk = ~clk;

    // The result side stalls at random unless a quiet stretch is running.
    always @(posedge clk)
    begin
        if (rst_n)
            rot.ready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic send_pair(input logic [15:0] pos, input logic [6:0] pair,
                             input logic [31:0] a, input logic [31:0] b);
        while (!calm && $urandom_range(99) < 24)
        begin
            feat.valid <= 1'b0;
            @(posedge clk);
        end
        feat.valid       <= 1'b1;
        feat.position    <= pos;
        feat.pair_no     <= pair;
        feat.lead_value  <= a;
        feat.trail_value <= b;
        @(posedge clk);
        while (!feat.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [RPE_CFG_INDEX_W-1:0] idx,
                             input logic [RPE_CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        feat.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return {{12{1'($urandom_range(1))}}, 20'($urandom())};
            2:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
        endcase
    endfunction

    task automatic random_items(input int count, input logic [7:0] half);
        logic [6:0]  pair;
        logic [15:0] pos;
        for (int i = 0; i < count; i++)
        begin
            pair = (half != 0 && $urandom_range(9) < 8) ? 7'($urandom_range(half - 1))
                                                        : 7'($urandom());
            pos  = $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(255));
            send_pair(pos, pair, random_value(), random_value());
        end
    endtask

    initial
    begin
        logic [21:0] lb;
        logic [7:0]  half;
        clk          = 1'b0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        feat.valid   = 1'b0;
        feat.position    = '0;
        feat.pair_no     = '0;
        feat.lead_value  = '0;
        feat.trail_value = '0;
        rot.ready    = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = RPE_REG_LOG2_BASE;
        cfg_ch.data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings: extremes of every field.
        send_pair(16'd0, 7'd0, 32'h00010000, 32'h00000000);
        send_pair(16'd1, 7'd0, 32'h00010000, 32'h00010000);
        send_pair(16'd65535, 7'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_pair(16'd65535, 7'd127, 32'h80000000, 32'h80000000);
        send_pair(16'd65535, 7'd63, 32'h7FFFFFFF, 32'h80000000);
        send_pair(16'd12345, 7'd1, 32'h80000000, 32'h7FFFFFFF);
        send_pair(16'd3, 7'd64, 32'hFFFFFFFF, 32'h00000001);
        send_pair(16'd100, 7'd32, 32'h00008000, 32'hFFFF8000);
        send_pair(16'd7, 7'd127, 32'h00000000, 32'h00000000);
        send_pair(16'd32768, 7'd5, 32'h7FFFFFFF, 32'h00000000);
        drain();

        // Largest base with one pair: huge exponents drive the angle to zero.
        write_reg(RPE_REG_LOG2_BASE, 22'h1FFFFF);
        write_reg(RPE_REG_HALF_SIZE, 22'd1);
        send_pair(16'd65535, 7'd127, 32'h7FFFFFFF, 32'h80000000);
        send_pair(16'd65535, 7'd1, 32'h12345678, 32'h87654321);
        random_items(80, 8'd1);
        drain();

        // Most negative base: very large frequencies.
        write_reg(RPE_REG_LOG2_BASE, 22'h200000);
        write_reg(RPE_REG_HALF_SIZE, 22'd128);
        send_pair(16'd65535, 7'd127, 32'h80000000, 32'h7FFFFFFF);
        send_pair(16'd1, 7'd1, 32'h00010000, 32'h00010000);
        random_items(80, 8'd128);
        drain();

        // Zero half size counts as one; zero base gives constant frequency.
        write_reg(RPE_REG_LOG2_BASE, 22'd0);
        write_reg(RPE_REG_HALF_SIZE, 22'd0);
        send_pair(16'd65535, 7'd127, 32'h7FFFFFFF, 32'h7FFFFFFF);
        calm = 1'b1;
        random_items(80, 8'd0);
        calm = 1'b0;
        drain();

        repeat (3)
        begin
            lb   = 22'($urandom());
            half = 8'($urandom_range(128, 1));
            write_reg(RPE_REG_LOG2_BASE, lb);
            write_reg(RPE_REG_HALF_SIZE, RPE_CFG_DATA_W'(half));
            random_items(70, half);
            drain();
        end

        write_reg(RPE_REG_LOG2_BASE, 22'd870824);
        write_reg(RPE_REG_HALF_SIZE, 22'd64);
        random_items(90, 8'd64);
        drain();

        repeat (120) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS rotary_position_embedding_top");
        else
            $display("FAIL rotary_position_embedding_top");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL rotary_position_embedding_top");
        $finish;
    end
endmodule
